// File: rtl/i2c_transaction_demux_defines.svh
// assertion macros for the i2c transaction demux
// define NO_ASSERTIONS to compile them out
`ifndef I2C_TRANSACTION_DEMUX_DEFINES_SVH
`define I2C_TRANSACTION_DEMUX_DEFINES_SVH

`ifndef NO_ASSERTIONS

// property that must hold at every clock edge outside reset
`define I2CTD_ASSERT(name, clk_s, rstn_s, prop, msg) \
  name: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define I2CTD_ASSERT_NEXT(name, clk_s, rstn_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`else

`define I2CTD_ASSERT(name, clk_s, rstn_s, prop, msg)
`define I2CTD_ASSERT_NEXT(name, clk_s, rstn_s, ante, cons, msg)

`endif

`endif

// File: rtl/i2ctd_pkg.sv
`timescale 1ns / 1ps

package i2ctd_pkg;

  // default table sizes
  localparam int SLAVE_SLOTS_DEF  = 128;
  localparam int PACKET_SLOTS_DEF = 32;

  // field widths
  localparam int KIND_W   = 4;
  localparam int SAMPLE_W = 64;
  localparam int BYTES_W  = 64;
  localparam int COUNT_W  = 4;
  localparam int ADDR_W   = 8;
  localparam int STREAM_W = 7;
  localparam int MAX_BYTES = 8;

  // command codes
  localparam logic [KIND_W-1:0] KIND_ADDR_READ  = 4'd0;
  localparam logic [KIND_W-1:0] KIND_ADDR_WRITE = 4'd1;
  localparam logic [KIND_W-1:0] KIND_STOP       = 4'd2;

  // one buffered packet
  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [SAMPLE_W-1:0] start_smp;
    logic [SAMPLE_W-1:0] end_smp;
    logic [BYTES_W-1:0]  bytes;
    logic [COUNT_W-1:0]  count;
  } pkt_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK_RD,
    ST_LOOK_CMP,
    ST_FLUSH_RD,
    ST_FLUSH_OUT
  } i2ctd_state_t;

  // clamp a byte count to eight
  function automatic logic [COUNT_W-1:0] sat_count(logic [COUNT_W-1:0] n);
    logic [COUNT_W-1:0] r;
    r = (n > COUNT_W'(MAX_BYTES)) ? COUNT_W'(MAX_BYTES) : n;
    return r;
  endfunction

  // zero the bytes at or above the count
  function automatic logic [BYTES_W-1:0] keep_bytes(logic [BYTES_W-1:0] v,
                                                     logic [COUNT_W-1:0] n);
    logic [BYTES_W-1:0] m;
    m = '0;
    for (int b = 0; b < MAX_BYTES; b++) begin
      if (COUNT_W'(b) < n) m[b*8 +: 8] = 8'hFF;
    end
    return v & m;
  endfunction

endpackage

// File: rtl/i2ctd_slave_table.sv
`timescale 1ns / 1ps

module i2ctd_slave_table #(
  parameter int SLAVE_SLOTS = i2ctd_pkg::SLAVE_SLOTS_DEF,
  parameter int IDX_W       = (SLAVE_SLOTS > 1) ? $clog2(SLAVE_SLOTS) : 1
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [IDX_W-1:0]           wr_idx,
  input  logic [i2ctd_pkg::ADDR_W-1:0] wr_addr,
  input  logic                       rd_en,
  input  logic [IDX_W-1:0]           rd_idx,
  input  logic [i2ctd_pkg::ADDR_W-1:0] key,
  output logic                       match
);
  import i2ctd_pkg::*;

  logic [ADDR_W-1:0] mem [SLAVE_SLOTS];
  logic [ADDR_W-1:0] rd_data_r;

  // table store
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_idx] <= wr_addr;
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= mem[rd_idx];
  end

  // shared comparator against the address being looked up
  assign match = (rd_data_r == key);

endmodule

// File: rtl/i2ctd_packet_buf.sv
`timescale 1ns / 1ps

module i2ctd_packet_buf #(
  parameter int PACKET_SLOTS = i2ctd_pkg::PACKET_SLOTS_DEF,
  parameter int IDX_W        = (PACKET_SLOTS > 1) ? $clog2(PACKET_SLOTS) : 1
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [IDX_W-1:0]    wr_idx,
  input  i2ctd_pkg::pkt_t     wr_pkt,
  input  logic                rd_en,
  input  logic [IDX_W-1:0]    rd_idx,
  output i2ctd_pkg::pkt_t     rd_pkt
);
  import i2ctd_pkg::*;

  pkt_t mem [PACKET_SLOTS];
  pkt_t rd_pkt_r;
  pkt_t wr_clean;

  // trim unused payload bytes on the way in
  always_comb begin
    wr_clean       = wr_pkt;
    wr_clean.bytes = keep_bytes(wr_pkt.bytes, wr_pkt.count);
  end

  // packet store
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_idx] <= wr_clean;
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) rd_pkt_r <= mem[rd_idx];
  end

  assign rd_pkt = rd_pkt_r;

endmodule

// File: rtl/i2c_transaction_demux.sv
`timescale 1ns / 1ps
// channel | direction | handshake            | payload
// in_     | input     | in_valid / in_ready   | kind, start/end sample, data bytes, count
// out_    | output    | out_valid / out_ready | stream, address, buffered packet, last flag
//
// Items are accepted only in the idle state. An address command then walks the slave
// table through one read port and one comparator, each entry a read state then a
// compare state: a hit returns to idle from the compare, a miss from the read once
// all N entries are searched. A stop with a stream emits each buffered packet by a
// buffer read, then the output, which waits while out_ready is held low.
// Reset clears the counts and the stream; the stores need no clearing pass.
`include "i2c_transaction_demux_defines.svh"

module i2c_transaction_demux #(
  parameter int SLAVE_SLOTS  = i2ctd_pkg::SLAVE_SLOTS_DEF,
  parameter int PACKET_SLOTS = i2ctd_pkg::PACKET_SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [i2ctd_pkg::KIND_W-1:0]    in_kind,
  input  logic [i2ctd_pkg::SAMPLE_W-1:0]  in_start_sample,
  input  logic [i2ctd_pkg::SAMPLE_W-1:0]  in_end_sample,
  input  logic [i2ctd_pkg::BYTES_W-1:0]   in_data_bytes,
  input  logic [i2ctd_pkg::COUNT_W-1:0]   in_data_count,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [i2ctd_pkg::STREAM_W-1:0]  out_stream_index,
  output logic [i2ctd_pkg::ADDR_W-1:0]    out_slave_address,
  output logic [i2ctd_pkg::KIND_W-1:0]    out_packet_kind,
  output logic [i2ctd_pkg::SAMPLE_W-1:0]  out_packet_start,
  output logic [i2ctd_pkg::SAMPLE_W-1:0]  out_packet_end,
  output logic [i2ctd_pkg::BYTES_W-1:0]   out_packet_bytes,
  output logic [i2ctd_pkg::COUNT_W-1:0]   out_packet_count,
  output logic                            out_last_of_flush
);
  import i2ctd_pkg::*;

  localparam int SIDX_W = (SLAVE_SLOTS > 1) ? $clog2(SLAVE_SLOTS) : 1;
  localparam int SCNT_W = $clog2(SLAVE_SLOTS + 1);
  localparam int BIDX_W = (PACKET_SLOTS > 1) ? $clog2(PACKET_SLOTS) : 1;
  localparam int BCNT_W = $clog2(PACKET_SLOTS + 1);
  localparam logic [SCNT_W-1:0] SLV_FULL = SCNT_W'(SLAVE_SLOTS);
  localparam logic [BCNT_W-1:0] BUF_FULL = BCNT_W'(PACKET_SLOTS);

  i2ctd_state_t state_r, state_nxt;

  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [SCNT_W-1:0] idx_r, idx_nxt;
  logic [SCNT_W-1:0] slv_cnt_r, slv_cnt_nxt;
  logic              stream_vld_r, stream_vld_nxt;
  logic [SIDX_W-1:0] stream_r, stream_nxt;
  logic [ADDR_W-1:0] stream_addr_r, stream_addr_nxt;
  logic [BCNT_W-1:0] buf_cnt_r, buf_cnt_nxt;
  logic [BCNT_W-1:0] fidx_r, fidx_nxt;

  logic              in_fire;
  logic              in_is_addr;
  logic              in_is_stop;
  logic [COUNT_W-1:0] in_cnt_sat;
  logic [ADDR_W-1:0] in_addr;
  pkt_t              wr_pkt;
  pkt_t              rd_pkt;
  logic [BCNT_W-1:0] fidx_inc;
  logic              flush_last;

  logic tbl_wr_en, tbl_rd_en, tbl_match;
  logic buf_wr_en, buf_rd_en;

  // input decode
  assign in_fire    = in_valid && in_ready;
  assign in_is_addr = in_kind inside {KIND_ADDR_READ, KIND_ADDR_WRITE};
  assign in_is_stop = (in_kind == KIND_STOP);
  assign in_cnt_sat = sat_count(in_data_count);
  assign in_addr    = (in_cnt_sat != '0) ? in_data_bytes[ADDR_W-1:0] : '0;

  always_comb begin
    wr_pkt.kind      = in_kind;
    wr_pkt.start_smp = in_start_sample;
    wr_pkt.end_smp   = in_end_sample;
    wr_pkt.bytes     = in_data_bytes;
    wr_pkt.count     = in_cnt_sat;
  end

  assign fidx_inc   = fidx_r + BCNT_W'(1);
  assign flush_last = (fidx_inc == buf_cnt_r);

  // slave table with its comparator
  i2ctd_slave_table #(
    .SLAVE_SLOTS (SLAVE_SLOTS),
    .IDX_W       (SIDX_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_idx  (slv_cnt_r[SIDX_W-1:0]),
    .wr_addr (addr_r),
    .rd_en   (tbl_rd_en),
    .rd_idx  (idx_r[SIDX_W-1:0]),
    .key     (addr_r),
    .match   (tbl_match)
  );

  // packet buffer
  i2ctd_packet_buf #(
    .PACKET_SLOTS (PACKET_SLOTS),
    .IDX_W        (BIDX_W)
  ) u_buf (
    .clk    (clk),
    .wr_en  (buf_wr_en),
    .wr_idx (buf_cnt_r[BIDX_W-1:0]),
    .wr_pkt (wr_pkt),
    .rd_en  (buf_rd_en),
    .rd_idx (fidx_r[BIDX_W-1:0]),
    .rd_pkt (rd_pkt)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_is_addr) state_nxt = ST_LOOK_RD;
          else if (in_is_stop && stream_vld_r) state_nxt = ST_FLUSH_RD;
        end
      end
      ST_LOOK_RD: begin
        if (idx_r == slv_cnt_r) state_nxt = ST_IDLE;
        else state_nxt = ST_LOOK_CMP;
      end
      ST_LOOK_CMP: begin
        if (tbl_match) state_nxt = ST_IDLE;
        else state_nxt = ST_LOOK_RD;
      end
      ST_FLUSH_RD: state_nxt = ST_FLUSH_OUT;
      ST_FLUSH_OUT: begin
        if (out_ready) state_nxt = flush_last ? ST_IDLE : ST_FLUSH_RD;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE:      in_ready  = 1'b1;
      ST_FLUSH_OUT: out_valid = 1'b1;
      default: begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
      end
    endcase
  end

  // datapath and store control
  always_comb begin
    addr_nxt        = addr_r;
    idx_nxt         = idx_r;
    slv_cnt_nxt     = slv_cnt_r;
    stream_vld_nxt  = stream_vld_r;
    stream_nxt      = stream_r;
    stream_addr_nxt = stream_addr_r;
    buf_cnt_nxt     = buf_cnt_r;
    fidx_nxt        = fidx_r;
    tbl_wr_en       = 1'b0;
    tbl_rd_en       = 1'b0;
    buf_wr_en       = 1'b0;
    buf_rd_en       = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          // keep the item while there is room
          if (buf_cnt_r < BUF_FULL) begin
            buf_wr_en   = 1'b1;
            buf_cnt_nxt = buf_cnt_r + BCNT_W'(1);
          end
          if (in_is_addr) begin
            addr_nxt = in_addr;
            idx_nxt  = '0;
          end else if (in_is_stop) begin
            if (stream_vld_r) begin
              fidx_nxt = '0;
            end else begin
              // no stream: drop the buffer
              buf_cnt_nxt = '0;
            end
          end
        end
      end
      ST_LOOK_RD: begin
        if (idx_r == slv_cnt_r) begin
          // searched every entry without a hit
          if (slv_cnt_r < SLV_FULL) begin
            tbl_wr_en       = 1'b1;
            stream_vld_nxt  = 1'b1;
            stream_nxt      = slv_cnt_r[SIDX_W-1:0];
            stream_addr_nxt = addr_r;
            slv_cnt_nxt     = slv_cnt_r + SCNT_W'(1);
          end else begin
            stream_vld_nxt = 1'b0;
          end
        end else begin
          tbl_rd_en = 1'b1;
        end
      end
      ST_LOOK_CMP: begin
        if (tbl_match) begin
          stream_vld_nxt  = 1'b1;
          stream_nxt      = idx_r[SIDX_W-1:0];
          stream_addr_nxt = addr_r;
        end else begin
          idx_nxt = idx_r + SCNT_W'(1);
        end
      end
      ST_FLUSH_RD: buf_rd_en = 1'b1;
      ST_FLUSH_OUT: begin
        if (out_ready) begin
          if (flush_last) begin
            buf_cnt_nxt    = '0;
            stream_vld_nxt = 1'b0;
          end else begin
            fidx_nxt = fidx_inc;
          end
        end
      end
      default: begin
        tbl_wr_en = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      slv_cnt_r    <= '0;
      stream_vld_r <= 1'b0;
      buf_cnt_r    <= '0;
      idx_r        <= '0;
      fidx_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      slv_cnt_r    <= slv_cnt_nxt;
      stream_vld_r <= stream_vld_nxt;
      buf_cnt_r    <= buf_cnt_nxt;
      idx_r        <= idx_nxt;
      fidx_r       <= fidx_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    addr_r        <= addr_nxt;
    stream_r      <= stream_nxt;
    stream_addr_r <= stream_addr_nxt;
  end

  // result item
  assign out_stream_index  = STREAM_W'(stream_r);
  assign out_slave_address = stream_addr_r;
  assign out_packet_kind   = rd_pkt.kind;
  assign out_packet_start  = rd_pkt.start_smp;
  assign out_packet_end    = rd_pkt.end_smp;
  assign out_packet_bytes  = rd_pkt.bytes;
  assign out_packet_count  = rd_pkt.count;
  assign out_last_of_flush = flush_last;

  // checks
  `I2CTD_ASSERT(a_flush_needs_stream, clk, rst_n, !out_valid || stream_vld_r, "item emitted with no stream")
  `I2CTD_ASSERT(a_one_side_busy, clk, rst_n, !(in_ready && out_valid), "input open during a flush")
  `I2CTD_ASSERT(a_buf_in_range, clk, rst_n, buf_cnt_r <= BUF_FULL, "buffer count overran")
  `I2CTD_ASSERT(a_tbl_in_range, clk, rst_n, slv_cnt_r <= SLV_FULL, "slave count overran")
  `I2CTD_ASSERT_NEXT(a_last_clears, clk, rst_n, out_valid && out_ready && out_last_of_flush, buf_cnt_r == '0 && !stream_vld_r, "flush end left state behind")

endmodule
